/* rtl/core/sjt_pkg.sv */
// Shared constants for the S-curve jerk-limited trajectory generator.
package sjt_pkg;

  localparam int VALUE_WIDTH_DEF = 48;
  localparam int COUNT_WIDTH_DEF = 20;

  // substep register is always 16 bits wide; nine of them need 20 bits
  localparam int SUBSTEP_W = 16;
  localparam int NINE_SUB_W = 20;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_JERK_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBSTEP_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_POS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_TOL       = 3'd4;

  // direction codes, two bit signed
  localparam logic [1:0] DIR_NEG  = 2'b11;
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

endpackage

/* rtl/core/scurve_jerk_trajectory_generator.sv */
// Top level of the seven-segment jerk-limited S-curve trajectory generator.
//
//  channel   | direction | handshake                   | content
//  ----------+-----------+-----------------------------+---------------------------------
//  cfg       | in        | cfg_we_i                    | register index, write data
//  s_axis    | in        | s_axis_tvalid_i/tready_o    | one control tick (setpoint, start)
//  m_axis    | out       | m_axis_tvalid_o/tready_i    | one result per tick
//
//  One tick per clock while results are taken; a tick is written into the queue at the accepting
//  edge and integrated into the output register when the back end takes it from the queue.
//  The rate is set by the state update: the saturating adds are combinational and feed the next tick.
//  Reset empties the queue and clears the motion state and the result valid; registers
//  return to their reset values (substep of one tick).
//  A stalled result holds the back end; the two-entry queue fills, then s_axis_tready_o drops.
module scurve_jerk_trajectory_generator #(
  parameter int VALUE_WIDTH = sjt_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = sjt_pkg::COUNT_WIDTH_DEF,
  localparam int IN_W  = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * VALUE_WIDTH + 4 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sjt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]        cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // setpoint, zero padded
  input  logic [IN_W-1:0]               s_axis_tdata_i,
  // start_req
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // position, velocity, acceleration, moving, direction, replan_flag, zero padded
  output logic [OUT_W-1:0]              m_axis_tdata_o
);
  import sjt_pkg::*;

  logic                     q_valid, q_ready, q_start;
  logic [VALUE_WIDTH-1:0]   q_setpoint;
  logic [3*VALUE_WIDTH+3:0] res_data;

  sjt_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_start_i   (s_axis_tuser_i),
    .in_setpoint_i(s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .q_valid_o    (q_valid),
    .q_ready_i    (q_ready),
    .q_start_o    (q_start),
    .q_setpoint_o (q_setpoint)
  );

  sjt_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_start_i   (q_start),
    .q_setpoint_i(q_setpoint),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res_data)
  );

  // top padding bits are zero
  assign m_axis_tdata_o = OUT_W'(res_data);

endmodule

/* rtl/core/sjt_front.sv */
// Front end: accepts ticks and queues them with their start flag for the back end.
module sjt_front #(
  parameter int VALUE_WIDTH = sjt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_start_i,
  input  logic [VALUE_WIDTH-1:0] in_setpoint_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output logic                   q_start_o,
  output logic [VALUE_WIDTH-1:0] q_setpoint_o
);
  import sjt_pkg::*;

  logic                   start_q    [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] setpoint_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]      cnt_q, cnt_d;
  logic                   push, pop;

  assign in_ready_o   = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o    = (cnt_q != '0);
  assign q_start_o    = start_q[rd_ptr_q];
  assign q_setpoint_o = setpoint_q[rd_ptr_q];

  assign push = in_valid_i & in_ready_o;
  assign pop  = q_valid_o & q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      start_q[wr_ptr_q]    <= in_start_i;
      setpoint_q[wr_ptr_q] <= in_setpoint_i;
    end
  end

endmodule

/* rtl/core/sjt_back.sv */
// Back end: configuration, motion state, jerk schedule, integration and result register.
module sjt_back #(
  parameter int VALUE_WIDTH = sjt_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = sjt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sjt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]           cfg_data_i,
  input  logic                             q_valid_i,
  output logic                             q_ready_o,
  input  logic                             q_start_i,
  input  logic [VALUE_WIDTH-1:0]           q_setpoint_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [3*VALUE_WIDTH+3:0]         out_data_o
);
  import sjt_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int EW = VW + 2;
  localparam int CMP_W = (COUNT_WIDTH > NINE_SUB_W) ? COUNT_WIDTH : NINE_SUB_W;
  localparam logic [CMP_W-1:0] CMAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic signed [EW-1:0] VMAX_E = {3'b000, {(VW-1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN_E = {3'b111, {(VW-1){1'b0}}};

  // configuration
  logic signed [VW-1:0] jerk_q, final_q;
  logic [VW-2:0]        lim_q, tol_q;
  // phase boundaries at 1,2,3,6,7,8,9 substeps, plus the clamped duration
  logic [CMP_W-1:0]     b1_q, b2_q, b3_q, b6_q, b7_q, b8_q, b9_q, dur_q;
  logic [CMP_W-1:0]     s_w, s9_w;

  // motion state
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic signed [VW-1:0]   acc_q, acc_d, vel_q, vel_d, pos_q, pos_d;
  logic                   exec_q, exec_d;
  logic [1:0]             ldir_q, dir_d;

  logic                   out_v_q;
  logic [3*VW+3:0]        out_q;
  logic                   fire;

  assign s_w  = CMP_W'(cfg_data_i[SUBSTEP_W-1:0]);
  assign s9_w = (s_w << 3) + s_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jerk_q  <= '0;
      final_q <= '0;
      lim_q   <= '0;
      tol_q   <= '0;
      b1_q    <= CMP_W'(1);
      b2_q    <= CMP_W'(2);
      b3_q    <= CMP_W'(3);
      b6_q    <= CMP_W'(6);
      b7_q    <= CMP_W'(7);
      b8_q    <= CMP_W'(8);
      b9_q    <= CMP_W'(9);
      dur_q   <= CMP_W'(9);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_JERK_STEP: jerk_q  <= cfg_data_i;
        REG_FINAL_POS: final_q <= cfg_data_i;
        REG_ACCEL_LIMIT: lim_q <= cfg_data_i[VW-2:0];
        REG_POS_TOL:   tol_q   <= cfg_data_i[VW-2:0];
        REG_SUBSTEP_TICKS: begin
          b1_q  <= s_w;
          b2_q  <= s_w << 1;
          b3_q  <= (s_w << 1) + s_w;
          b6_q  <= (s_w << 2) + (s_w << 1);
          b7_q  <= (s_w << 3) - s_w;
          b8_q  <= s_w << 3;
          b9_q  <= s9_w;
          dur_q <= (s9_w > CMAX) ? CMAX : s9_w;
        end
        default: ;
      endcase
    end
  end

  // one tick of the move
  logic [COUNT_WIDTH-1:0]  tick_eff;
  logic                    exec_eff, done;
  logic [CMP_W-1:0]        t_ext, t_w;
  logic signed [VW:0]      jerk_x, jerk_sel, diff, tol_x;
  logic signed [EW-1:0]    acc_sum, vel_sum, pos_sum;
  logic signed [VW-1:0]    acc_sat, lim_s, acc_new, vel_new, pos_new;

  always_comb begin
    tick_eff = q_start_i ? '0 : tick_q;
    exec_eff = q_start_i | exec_q;
    t_ext    = CMP_W'(tick_eff);
    t_w      = (t_ext < dur_q) ? t_ext : dur_q;
    done     = (t_w >= dur_q);

    jerk_x = {jerk_q[VW-1], jerk_q};
    priority if (t_w < b1_q) jerk_sel = jerk_x;
    else if (t_w < b2_q)     jerk_sel = '0;
    else if (t_w < b3_q)     jerk_sel = -jerk_x;
    else if (t_w < b6_q)     jerk_sel = '0;
    else if (t_w < b7_q)     jerk_sel = -jerk_x;
    else if (t_w < b8_q)     jerk_sel = '0;
    else if (t_w < b9_q)     jerk_sel = jerk_x;
    else                     jerk_sel = '0;

    acc_sum = {{2{acc_q[VW-1]}}, acc_q} + {jerk_sel[VW], jerk_sel};
    if (acc_sum > VMAX_E)      acc_sat = VMAX_E[VW-1:0];
    else if (acc_sum < VMIN_E) acc_sat = VMIN_E[VW-1:0];
    else                       acc_sat = acc_sum[VW-1:0];

    lim_s   = {1'b0, lim_q};
    acc_new = acc_sat;
    if (lim_q != '0) begin
      if (acc_sat > lim_s)       acc_new = lim_s;
      else if (acc_sat < -lim_s) acc_new = -lim_s;
    end

    vel_sum = {{2{vel_q[VW-1]}}, vel_q} + {{2{acc_new[VW-1]}}, acc_new};
    if (vel_sum > VMAX_E)      vel_new = VMAX_E[VW-1:0];
    else if (vel_sum < VMIN_E) vel_new = VMIN_E[VW-1:0];
    else                       vel_new = vel_sum[VW-1:0];

    pos_sum = {{2{pos_q[VW-1]}}, pos_q} + {{2{vel_new[VW-1]}}, vel_new};
    if (pos_sum > VMAX_E)      pos_new = VMAX_E[VW-1:0];
    else if (pos_sum < VMIN_E) pos_new = VMIN_E[VW-1:0];
    else                       pos_new = pos_sum[VW-1:0];

    // deadband on the distance still to go, against the position before the tick
    diff  = {q_setpoint_i[VW-1], q_setpoint_i} - {pos_q[VW-1], pos_q};
    tol_x = {2'b00, tol_q};
    priority if (diff > tol_x) dir_d = DIR_POS;
    else if (diff < -tol_x)    dir_d = DIR_NEG;
    else                       dir_d = DIR_NONE;

    tick_d = tick_q;
    acc_d  = acc_q;
    vel_d  = vel_q;
    pos_d  = pos_q;
    exec_d = exec_eff;
    if (q_start_i) tick_d = '0;
    if (exec_eff) begin
      acc_d  = acc_new;
      vel_d  = vel_new;
      pos_d  = pos_new;
      tick_d = (tick_eff != CNT_MAX) ? tick_eff + 1'b1 : tick_eff;
      if (done) begin
        exec_d = 1'b0;
        pos_d  = final_q;
      end
    end
  end

  assign q_ready_o = !out_v_q || out_ready_i;
  assign fire      = q_valid_i && q_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      acc_q   <= '0;
      vel_q   <= '0;
      pos_q   <= '0;
      exec_q  <= 1'b0;
      ldir_q  <= DIR_NONE;
      out_v_q <= 1'b0;
    end else begin
      if (fire) begin
        tick_q <= tick_d;
        acc_q  <= acc_d;
        vel_q  <= vel_d;
        pos_q  <= pos_d;
        exec_q <= exec_d;
        ldir_q <= dir_d;
      end
      if (fire)             out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= {dir_d != ldir_q, dir_d, exec_d, acc_d, vel_d, pos_d};
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/sjt_checker.sv */
// Port-level checks for the trajectory generator, bound to the top level.
module sjt_checker #(
  parameter int VALUE_WIDTH = sjt_pkg::VALUE_WIDTH_DEF,
  localparam int OUT_W = ((3 * VALUE_WIDTH + 4 + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);
  import sjt_pkg::*;

  localparam int DIR_LSB = 3 * VALUE_WIDTH + 1;

  // reset empties the result register by the next edge
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // an output that stays empty means the queue is not full, so a tick can be taken
  a_drained_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o && $past(!m_axis_tvalid_o)) |-> s_axis_tready_o)
    else $error("input stalled although the back end is idle");

  // a tick taken while the output is empty is followed by a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o && $past(!m_axis_tvalid_o))
      |=> ##1 m_axis_tvalid_o)
    else $error("result missing after tick");

  // direction is -1, 0 or +1 only
  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[DIR_LSB+1:DIR_LSB] != 2'b10)
    else $error("illegal direction code");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind scurve_jerk_trajectory_generator sjt_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_sjt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
